>>> hdl/ose_pkg.sv
package ose_pkg;

  // operation codes carried in the kind field
  localparam logic [3:0] KIND_PUSH  = 4'd0;
  localparam logic [3:0] KIND_POP   = 4'd1;
  localparam logic [3:0] KIND_ROLL  = 4'd2;
  localparam logic [3:0] KIND_NIP   = 4'd3;
  localparam logic [3:0] KIND_TUCK  = 4'd4;
  localparam logic [3:0] KIND_DUP   = 4'd5;
  localparam logic [3:0] KIND_SWAP  = 4'd6;
  localparam logic [3:0] KIND_DROP  = 4'd7;
  localparam logic [3:0] KIND_COUNT = 4'd8;
  localparam logic [3:0] KIND_SUM   = 4'd9;
  localparam logic [3:0] KIND_SUMSQ = 4'd10;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_FEW    = 2'd2;
  localparam logic [1:0] ST_BADIDX = 2'd3;

  // q16.16 limits and the running cap of the sum of q32.32 squares
  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [63:0] SQ_CAP = 64'h0001_0000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RD1,
    S_RD2,
    S_WR2,
    S_WR3,
    S_RKEEP,
    S_RSHIFT,
    S_RLAST,
    S_STREAM,
    S_SFIN,
    S_DONE
  } st_t;

  typedef struct packed {
    logic clr;
    logic sq;
    logic vld;
  } acc_ctl_t;

endpackage

>>> hdl/ose_accum.sv
module ose_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  ose_pkg::acc_ctl_t ctl,
  input  logic [31:0]       data,
  output logic              busy,
  output logic [31:0]       result
);
  import ose_pkg::*;

  logic [31:0] mag;
  logic [63:0] term_nxt;
  logic [63:0] term_r;
  logic        tv_r;
  logic [63:0] acc_r;
  logic [63:0] acc_sum;
  logic [63:0] acc_nxt;

  assign mag = data[31] ? (~data + 32'd1) : data;

  always_comb begin
    if (ctl.sq) begin
      term_nxt = 64'(mag) * 64'(mag);
    end else begin
      term_nxt = {{32{data[31]}}, data};
    end
  end

  assign acc_sum = acc_r + term_r;

  // squares saturate at the cap after every term
  always_comb begin
    if (ctl.sq && (acc_sum >= SQ_CAP)) begin
      acc_nxt = SQ_CAP;
    end else begin
      acc_nxt = acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else if (ctl.clr) begin
      tv_r <= 1'b0;
    end else begin
      tv_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      term_r <= term_nxt;
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (tv_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    if (ctl.sq) begin
      if (acc_r[63:47] != '0) begin
        result = Q_MAX;
      end else begin
        result = acc_r[47:16];
      end
    end else if (!acc_r[63] && (acc_r[62:31] != '0)) begin
      result = Q_MAX;
    end else if (acc_r[63] && (acc_r[62:31] != '1)) begin
      result = Q_MIN;
    end else begin
      result = acc_r[31:0];
    end
  end

  assign busy = tv_r;

endmodule

>>> hdl/operand_stack_engine.sv
// Operand stack of signed q16.16 words, one operation per input transaction and one result
// transaction per input. The elements sit in a single-port-write, registered-read memory, so
// every access is sequenced one read and one write per cycle. Sum and sum of squares walk every
// stored element through the read port and a registered multiply-add unit. A new transaction is
// accepted while the previous result still waits on the output register.
module operand_stack_engine #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_kind,
  input  logic signed [31:0] in_operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_result_value,
  output logic [1:0]  out_status,
  output logic [5:0]  out_depth,
  output logic        out_underflow
);
  import ose_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  st_t state_r, state_nxt;

  logic [31:0]   mem [STACK_DEPTH];
  logic [31:0]   rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          we;

  logic [3:0]    kind_r;
  logic [31:0]   opnd_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          flag_r, flag_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   resv_r, resv_nxt;
  logic [31:0]   a_r, a_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rdv_r;
  logic          out_valid_r;

  logic          accept;
  logic          empty, few, full;
  logic [AW-1:0] top_addr;
  logic [15:0]   roll_hi;
  logic          neg_zero;
  logic          roll_zero, roll_bad;
  logic [CW-1:0] roll_pos;
  logic          shift_last;
  logic          stream_issue, stream_done;

  acc_ctl_t      acc_ctl;
  logic          acc_busy;
  logic [31:0]   acc_result;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign empty    = (cnt_r == '0);
  assign few      = (cnt_r < CW'(2));
  assign full     = (cnt_r == CW'(STACK_DEPTH));
  assign top_addr = AW'(cnt_r - CW'(1));

  // roll index: popped top truncated toward zero, cnt_r already holds the remaining depth
  assign roll_hi   = rd_data_r[31:16];
  assign neg_zero  = (roll_hi == 16'hFFFF) && (rd_data_r[15:0] != '0);
  assign roll_zero = rd_data_r[31] ? neg_zero : (roll_hi == '0);
  assign roll_bad  = rd_data_r[31] ? (!neg_zero || empty)
                                   : (32'(roll_hi) >= 32'(cnt_r));
  assign roll_pos  = cnt_r - CW'(1) - CW'(roll_hi);

  assign shift_last   = (idx_r == cnt_r);
  assign stream_issue = (state_r == S_STREAM) && (idx_r < cnt_r);
  assign stream_done  = (state_r == S_STREAM) && !stream_issue && !rdv_r && !acc_busy;

  assign acc_ctl.clr = (state_r == S_EXEC);
  assign acc_ctl.sq  = (kind_r == KIND_SUMSQ);
  assign acc_ctl.vld = rdv_r;

  ose_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (acc_ctl),
    .data   (rd_data_r),
    .busy   (acc_busy),
    .result (acc_result)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (kind_r) inside
          KIND_POP, KIND_ROLL:   state_nxt = empty ? S_DONE : S_RD1;
          KIND_NIP, KIND_SWAP:   state_nxt = few ? S_DONE : S_RD1;
          KIND_TUCK:             state_nxt = (few || full) ? S_DONE : S_RD1;
          KIND_DUP:              state_nxt = (empty || full) ? S_DONE : S_RD1;
          KIND_SUM, KIND_SUMSQ:  state_nxt = full ? S_DONE : S_STREAM;
          default:               state_nxt = S_DONE;
        endcase
      end
      S_RD1: begin
        unique case (kind_r) inside
          KIND_SWAP, KIND_TUCK: state_nxt = S_RD2;
          KIND_ROLL:            state_nxt = (roll_bad || roll_zero) ? S_DONE : S_RKEEP;
          default:              state_nxt = S_DONE;
        endcase
      end
      S_RD2:    state_nxt = S_WR2;
      S_WR2:    state_nxt = (kind_r == KIND_TUCK) ? S_WR3 : S_DONE;
      S_WR3:    state_nxt = S_DONE;
      S_RKEEP:  state_nxt = S_RSHIFT;
      S_RSHIFT: state_nxt = shift_last ? S_RLAST : S_RSHIFT;
      S_RLAST:  state_nxt = S_DONE;
      S_STREAM: state_nxt = stream_done ? S_SFIN : S_STREAM;
      S_SFIN:   state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    we         = 1'b0;
    wr_addr    = top_addr;
    wr_data    = rd_data_r;
    rd_addr    = top_addr;
    cnt_nxt    = cnt_r;
    flag_nxt   = flag_r;
    status_nxt = status_r;
    resv_nxt   = resv_r;
    a_nxt      = a_r;
    idx_nxt    = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = ST_OK;
          resv_nxt   = '0;
        end
      end
      S_EXEC: begin
        unique case (kind_r) inside
          KIND_PUSH: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              we      = 1'b1;
              wr_addr = AW'(cnt_r);
              wr_data = opnd_r;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          KIND_POP: begin
            if (empty) begin
              flag_nxt   = 1'b1;
              status_nxt = ST_FEW;
            end
          end
          KIND_ROLL: begin
            if (empty) begin
              status_nxt = ST_FEW;
            end else begin
              cnt_nxt  = cnt_r - CW'(1);
              flag_nxt = 1'b0;
            end
          end
          KIND_NIP, KIND_SWAP: begin
            if (few) status_nxt = ST_FEW;
          end
          KIND_TUCK: begin
            if (few) begin
              status_nxt = ST_FEW;
            end else if (full) begin
              status_nxt = ST_FULL;
            end
          end
          KIND_DUP: begin
            if (empty) begin
              status_nxt = ST_FEW;
            end else if (full) begin
              status_nxt = ST_FULL;
            end
          end
          KIND_DROP: begin
            if (empty) begin
              status_nxt = ST_FEW;
            end else begin
              cnt_nxt = cnt_r - CW'(1);
            end
          end
          KIND_COUNT: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              we      = 1'b1;
              wr_addr = AW'(cnt_r);
              wr_data = 32'(cnt_r) << 16;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          KIND_SUM, KIND_SUMSQ: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              idx_nxt = '0;
            end
          end
          default: begin
          end
        endcase
      end
      S_RD1: begin
        a_nxt = rd_data_r;
        unique case (kind_r) inside
          KIND_POP: begin
            resv_nxt = rd_data_r;
            cnt_nxt  = cnt_r - CW'(1);
            flag_nxt = 1'b0;
          end
          KIND_DUP: begin
            we      = 1'b1;
            wr_addr = AW'(cnt_r);
            cnt_nxt = cnt_r + CW'(1);
          end
          KIND_NIP: begin
            we      = 1'b1;
            wr_addr = AW'(cnt_r - CW'(2));
            cnt_nxt = cnt_r - CW'(1);
          end
          KIND_SWAP, KIND_TUCK: begin
            rd_addr = AW'(cnt_r - CW'(2));
          end
          KIND_ROLL: begin
            if (roll_bad) begin
              status_nxt = ST_BADIDX;
            end else if (!roll_zero) begin
              rd_addr = AW'(roll_pos);
              idx_nxt = roll_pos + CW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_RD2: begin
        we = 1'b1;
      end
      S_WR2: begin
        we      = 1'b1;
        wr_addr = AW'(cnt_r - CW'(2));
        wr_data = a_r;
      end
      S_WR3: begin
        we      = 1'b1;
        wr_addr = AW'(cnt_r);
        wr_data = a_r;
        cnt_nxt = cnt_r + CW'(1);
      end
      S_RKEEP: begin
        a_nxt   = rd_data_r;
        rd_addr = AW'(idx_r);
        idx_nxt = idx_r + CW'(1);
      end
      S_RSHIFT: begin
        // data read at idx_r - 1 moves one place down
        we      = 1'b1;
        wr_addr = AW'(idx_r - CW'(2));
        if (!shift_last) begin
          rd_addr = AW'(idx_r);
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_RLAST: begin
        we      = 1'b1;
        wr_data = a_r;
      end
      S_STREAM: begin
        if (stream_issue) begin
          rd_addr = AW'(idx_r);
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_SFIN: begin
        we      = 1'b1;
        wr_addr = AW'(cnt_r);
        wr_data = acc_result;
        cnt_nxt = cnt_r + CW'(1);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      flag_r      <= 1'b0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      flag_r  <= flag_nxt;
      rdv_r   <= stream_issue;
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      opnd_r <= in_operand;
    end
    status_r <= status_nxt;
    resv_r   <= resv_nxt;
    a_r      <= a_nxt;
    idx_r    <= idx_nxt;
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_result_value <= resv_r;
      out_status       <= status_r;
      out_depth        <= 6'(cnt_r);
      out_underflow    <= flag_r;
    end
  end

endmodule

>>> hdl/ose_checker.sv
module ose_checker #(
  parameter int STACK_DEPTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_value,
  input logic [1:0]  out_status,
  input logic [5:0]  out_depth,
  input logic        out_underflow
);
  import ose_pkg::*;

  // only a successful pop returns a nonzero value
  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_value != '0) |-> out_status == ST_OK)
    else $error("nonzero result value with failing status");

  // a full report means the stack is at capacity
  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_depth == 6'(STACK_DEPTH))
    else $error("stack full reported below capacity");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (STACK_DEPTH > 63) || (out_depth <= 6'(STACK_DEPTH)))
    else $error("depth beyond capacity");

  // one transaction in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value)
      && $stable(out_status) && $stable(out_depth) && $stable(out_underflow))
    else $error("stalled result changed");

endmodule

bind operand_stack_engine ose_checker #(.STACK_DEPTH(STACK_DEPTH)) u_ose_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_value (out_result_value),
  .out_status       (out_status),
  .out_depth        (out_depth),
  .out_underflow    (out_underflow)
);

>>> test/operand_stack_checker.sv
module operand_stack_checker #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [3:0]         in_kind,
  input  logic signed [31:0] in_operand,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_result_value,
  input  logic [1:0]         out_status,
  input  logic [5:0]         out_depth,
  input  logic               out_underflow,
  output int                 mismatch_count,
  output int                 expected_left
);
  import ose_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [5:0]  depth;
    logic        underflow;
  } stack_result_t;

  logic [31:0]   shadow_mem [STACK_DEPTH];
  int            shadow_count;
  logic          shadow_uflag;
  stack_result_t pending_results [$];

  function automatic logic [31:0] clamp_q(input longint x);
    if (x > longint'(signed'(Q_MAX))) return Q_MAX;
    if (x < longint'(signed'(Q_MIN))) return Q_MIN;
    return x[31:0];
  endfunction

  function automatic void put_word(input logic [31:0] w);
    shadow_mem[shadow_count] = w;
    shadow_count++;
  endfunction

  function automatic stack_result_t step_stack(input logic [3:0] kind,
                                               input logic [31:0] operand);
    stack_result_t      r;
    logic signed [31:0] w;
    logic [31:0]        keep;
    longint             acc;
    longint             idx;
    longint unsigned    sq;
    longint unsigned    mag;
    int                 pos;
    logic               full;
    r = '0;
    r.status = ST_OK;
    full = (shadow_count >= STACK_DEPTH);
    case (kind)
      KIND_PUSH: begin
        if (full) r.status = ST_FULL;
        else put_word(operand);
      end
      KIND_POP: begin
        if (shadow_count == 0) begin
          shadow_uflag = 1'b1;
          r.status = ST_FEW;
        end else begin
          shadow_uflag = 1'b0;
          shadow_count--;
          r.value = shadow_mem[shadow_count];
        end
      end
      KIND_ROLL: begin
        if (shadow_count == 0) r.status = ST_FEW;
        else begin
          shadow_uflag = 1'b0;
          shadow_count--;
          w = shadow_mem[shadow_count];
          acc = w;
          // index truncates toward zero, it stays popped even when bad
          idx = (acc < 0) ? -((-acc) >>> 16) : (acc >>> 16);
          if (idx < 0 || idx >= shadow_count) r.status = ST_BADIDX;
          else begin
            pos = shadow_count - 1 - int'(idx);
            keep = shadow_mem[pos];
            for (int i = pos; i < shadow_count - 1; i++) shadow_mem[i] = shadow_mem[i + 1];
            shadow_mem[shadow_count - 1] = keep;
          end
        end
      end
      KIND_NIP: begin
        if (shadow_count < 2) r.status = ST_FEW;
        else begin
          shadow_mem[shadow_count - 2] = shadow_mem[shadow_count - 1];
          shadow_count--;
        end
      end
      KIND_TUCK: begin
        if (shadow_count < 2) r.status = ST_FEW;
        else if (full) r.status = ST_FULL;
        else begin
          keep = shadow_mem[shadow_count - 1];
          shadow_mem[shadow_count - 1] = shadow_mem[shadow_count - 2];
          shadow_mem[shadow_count - 2] = keep;
          put_word(keep);
        end
      end
      KIND_DUP: begin
        if (shadow_count == 0) r.status = ST_FEW;
        else if (full) r.status = ST_FULL;
        else put_word(shadow_mem[shadow_count - 1]);
      end
      KIND_SWAP: begin
        if (shadow_count < 2) r.status = ST_FEW;
        else begin
          keep = shadow_mem[shadow_count - 1];
          shadow_mem[shadow_count - 1] = shadow_mem[shadow_count - 2];
          shadow_mem[shadow_count - 2] = keep;
        end
      end
      KIND_DROP: begin
        if (shadow_count == 0) r.status = ST_FEW;
        else shadow_count--;
      end
      KIND_COUNT: begin
        if (full) r.status = ST_FULL;
        else put_word(clamp_q(longint'(shadow_count) <<< 16));
      end
      KIND_SUM: begin
        if (full) r.status = ST_FULL;
        else begin
          acc = 0;
          for (int i = 0; i < shadow_count; i++) begin
            w = shadow_mem[i];
            acc += w;
          end
          put_word(clamp_q(acc));
        end
      end
      KIND_SUMSQ: begin
        if (full) r.status = ST_FULL;
        else begin
          sq = 0;
          for (int i = 0; i < shadow_count; i++) begin
            w = shadow_mem[i];
            acc = w;
            mag = (acc < 0) ? -acc : acc;
            sq += mag * mag;
            // running total is capped, squares are q32.32
            if (sq >= SQ_CAP) sq = SQ_CAP;
          end
          sq = sq >> 16;
          put_word((sq > Q_MAX) ? Q_MAX : sq[31:0]);
        end
      end
      default: begin
      end
    endcase
    r.depth = 6'(shadow_count);
    r.underflow = shadow_uflag;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    stack_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      shadow_uflag = 1'b0;
      pending_results.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result transaction with none expected: value=%h status=%0d",
                   $time, out_result_value, out_status);
          $display("%0t:   depth=%0d underflow=%0b", $time, out_depth, out_underflow);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_result_value !== want.value) begin
            $display("%0t: value mismatch, expected %h got %h",
                     $time, want.value, out_result_value);
            mismatch_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, want.status, out_status);
            mismatch_count++;
          end
          if (out_depth !== want.depth) begin
            $display("%0t: depth mismatch, expected %0d got %0d",
                     $time, want.depth, out_depth);
            mismatch_count++;
          end
          if (out_underflow !== want.underflow) begin
            $display("%0t: underflow mismatch, expected %0b got %0b",
                     $time, want.underflow, out_underflow);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) pending_results.push_back(step_stack(in_kind, in_operand));
    end
    expected_left <= pending_results.size();
  end

endmodule

>>> test/testbench.sv
module testbench;
  import ose_pkg::*;

  localparam int STACK_DEPTH   = 32;
  localparam int PERIOD        = 8;
  localparam int RESET_CYCLES  = 11;
  localparam int TOTAL_ITEMS   = 825;
  localparam int QUIET_ITEMS   = 120;
  localparam int HOLD_AT       = 300;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 400000;

  // highest undefined operation code
  localparam logic [3:0] KIND_TOP = 4'hF;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_ROLL} mode_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         in_kind;
  logic signed [31:0] in_operand;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_result_value;
  logic [1:0]         out_status;
  logic [5:0]         out_depth;
  logic               out_underflow;
  int                 mismatch_count;
  int                 expected_left;

  int issued = 0;
  int cycles = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req = 1'b0;

  always #(PERIOD / 2) clk = ~clk;

  operand_stack_engine #(.STACK_DEPTH(STACK_DEPTH)) i_dut (.*);

  operand_stack_checker #(.STACK_DEPTH(STACK_DEPTH)) i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_op(input logic [3:0] kind, input logic [31:0] operand);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_operand <= operand;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    issued++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      1, 2: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
      default: return $urandom();
    endcase
  endfunction

  // integer part mostly within the stack, fraction random, sometimes negative
  function automatic logic [31:0] roll_index();
    logic [31:0] v;
    v = {16'($urandom_range(0, STACK_DEPTH + 2)), 16'($urandom())};
    if ($urandom_range(0, 7) == 0) v = -v;
    return v;
  endfunction

  function automatic logic [3:0] pick_kind(input mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 93) return 4'($urandom_range(0, KIND_TOP));
    case (mode)
      MODE_FILL: begin
        if (r < 50) return KIND_PUSH;
        if (r < 60) return KIND_DUP;
        if (r < 67) return KIND_COUNT;
        if (r < 75) return KIND_SUM;
        if (r < 83) return KIND_SUMSQ;
        if (r < 89) return KIND_TUCK;
        return KIND_SWAP;
      end
      MODE_DRAIN: begin
        if (r < 40) return KIND_POP;
        if (r < 60) return KIND_DROP;
        if (r < 75) return KIND_NIP;
        if (r < 83) return KIND_SWAP;
        return KIND_SUM;
      end
      default: return 4'($urandom_range(KIND_PUSH, KIND_SUMSQ));
    endcase
  endfunction

  initial begin : result_sink
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left == 0 && run_left == 0 && rx_idle_on) begin
        stall_left = $urandom_range(1, 16);
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (run_left > 0) run_left--;
      end
    end
  end

  initial begin : stimulus
    mode_t mode;
    int    blk_len;
    bit    hold_done;
    hold_done  = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_kind    = KIND_PUSH;
    in_operand = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // operations that need an element fail on an empty stack
    send_op(KIND_POP, '0);
    send_op(KIND_ROLL, '0);
    send_op(KIND_DUP, '0);
    send_op(KIND_DROP, '0);
    send_op(KIND_SWAP, '0);
    send_op(KIND_NIP, '0);
    send_op(KIND_TUCK, '0);
    send_op(KIND_TOP, '1);
    send_op(KIND_PUSH, Q_MAX);
    send_op(KIND_TUCK, '0);
    send_op(KIND_POP, '0);
    send_op(KIND_PUSH, Q_MIN);
    send_op(KIND_PUSH, Q_MAX);
    send_op(KIND_SUM, '0);
    send_op(KIND_SUMSQ, '0);
    send_op(KIND_COUNT, '0);
    // roll by 2.5, by -0.5 (truncates to zero), by -1.0 and by 100.0
    send_op(KIND_PUSH, 32'h0002_8000);
    send_op(KIND_ROLL, '0);
    send_op(KIND_PUSH, 32'hFFFF_8000);
    send_op(KIND_ROLL, '0);
    send_op(KIND_PUSH, 32'hFFFF_0000);
    send_op(KIND_ROLL, '0);
    send_op(KIND_PUSH, 32'h0064_0000);
    send_op(KIND_ROLL, '0);
    send_op(KIND_SWAP, '0);

    while (issued < TOTAL_ITEMS) begin
      mode = mode_t'($urandom_range(MODE_FILL, MODE_ROLL));
      blk_len = (mode == MODE_FILL) ? $urandom_range(30, 70) : $urandom_range(16, 60);
      repeat (blk_len) begin
        if (issued < TOTAL_ITEMS) begin
          if (!hold_done && issued >= HOLD_AT) begin
            hold_req = 1'b1;
            hold_done = 1'b1;
          end
          if (issued >= TOTAL_ITEMS - QUIET_ITEMS) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
          end
          if (mode == MODE_ROLL && $urandom_range(0, 9) < 7) begin
            send_op(KIND_PUSH, roll_index());
            send_op(KIND_ROLL, $urandom());
          end else begin
            send_op(pick_kind(mode), pick_operand());
          end
        end
      end
    end
    in_valid <= 1'b0;

    wait (expected_left == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_left == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
